// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define BAI_ASSERT(lbl, prp, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prp) else $error(msg);

// clocked check, also live during reset
`define BAI_ASSERT_ALWAYS(lbl, prp, msg) \
   lbl: assert property (@(posedge clock) prp) else $error(msg);

`endif

// ===== rtl/bai_pkg.sv =====
package bai_pkg;

   localparam int MAX_ROW_LENGTH = 1024;
   localparam int MAX_ROWS       = 1024;
   localparam int COORD_W        = 32;
   localparam int LINE_DEPTH     = MAX_ROW_LENGTH;
   localparam int ADDR_W         = $clog2(LINE_DEPTH);
   localparam int CNT_W          = 10;
   localparam int REG_W          = 11;
   localparam int DIFF_W         = COORD_W + 1;
   localparam int MUL_W          = 66;
   localparam int MUL_LIMBS      = 3;
   localparam int LIMB_W         = MUL_W / MUL_LIMBS;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int WIDE_W         = 130;
   localparam int QUO_W          = 61;
   localparam int REM_W          = WIDE_W + 1;
   localparam int COS_ENTRIES    = 128;
   localparam int IDX_W          = $clog2(COS_ENTRIES);
   localparam int GRAY_W         = 8;
   localparam int PIX_W          = 10;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [REG_W-1:0] ROW_LENGTH_RESET   = 11'd640;
   localparam logic [REG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;
   localparam logic [REG_W-1:0] MIN_ROW_LENGTH     = 11'd2;
   localparam logic [REG_W-1:0] MIN_ROWS           = 11'd1;

   localparam logic REG_IDX_ROW_LENGTH   = 1'b0;
   localparam logic REG_IDX_IMAGE_HEIGHT = 1'b1;
   localparam int   REG_IDX_BIT          = 2;

   localparam logic [GRAY_W-1:0] GRAY_TOP  = 8'd255;
   localparam logic [GRAY_W-1:0] GRAY_BACK = 8'd254;

   localparam logic [63:0] PI_Q61     = 64'h6487ED5110B4611A;
   localparam logic [63:0] ANGLE_STEP = PI_Q61 / 64'd255;
   localparam logic [63:0] TAYLOR_DIV [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                               64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   typedef logic [QUO_W-1:0] cos_sq_tab_type [COS_ENTRIES];

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic             zero;
      logic             npos;
      logic [PIX_W-1:0] pixel_row;
      logic [PIX_W-1:0] pixel_col;
      logic             frame_end;
   } side_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic [PIX_W-1:0]  pixel_row;
      logic [PIX_W-1:0]  pixel_col;
      logic              frame_end;
   } rsp_type;

   // Q1.60 square of the Q1.30 cosine of k*pi/255, Taylor series in integer steps
   function automatic cos_sq_tab_type build_cos_sq();
      cos_sq_tab_type    tab;
      logic [63:0]        ang;
      logic [63:0]        ang_sq;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic [63:0]        mag_sq;
      logic signed [63:0] sum;
      for (int k = 0; k < COS_ENTRIES; k++) begin
         ang    = (ANGLE_STEP * 64'(k)) >> 31;
         ang_sq = (ang * ang) >> 30;
         term   = 64'd1 << 30;
         sum    = 64'sd1 <<< 30;
         for (int n = 0; n < 10; n++) begin
            term = ((term * ang_sq) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         mag    = 64'(sum);
         mag_sq = mag * mag;
         tab[k] = mag_sq[QUO_W-1:0];
      end
      return tab;
   endfunction

   localparam cos_sq_tab_type COS_SQ = build_cos_sq();

endpackage

// ===== rtl/bai_if.sv =====
interface bai_req_if import bai_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;
   logic signed [COORD_W-1:0] z;

   modport source (output valid, x, y, z, input ready);
   modport sink (input valid, x, y, z, output ready);
endinterface

interface bai_rsp_if import bai_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GRAY_W-1:0] gray;
   logic [PIX_W-1:0]  pixel_row;
   logic [PIX_W-1:0]  pixel_col;
   logic              frame_end;

   modport source (output valid, gray, pixel_row, pixel_col, frame_end, input ready);
   modport sink (input valid, gray, pixel_row, pixel_col, frame_end, output ready);
endinterface

// ===== rtl/bearing_angle_image_pixel_top.sv =====
// channel  | dir | transfer          | payload
// req_if   | in  | valid & ready     | x, y, z (signed Q16.16)
// rsp_if   | out | valid & ready     | gray, pixel_row, pixel_col, frame_end
// csr_*    | in  | psel&penable&pwrite | row_length @0x0, image_height @0x4
// One point per cycle while req_if.ready is high; the pipeline depth is set mostly
// by the 61-step quotient pipeline and the 8-step cosine table search.
// Line store: one write and one read per point, read of the next column ahead.
// Synchronous reset clears valids, counters and CSR registers; the store is not cleared.
// A stalled output fills a skid stage; req_if.ready drops only while it is full.
`include "assert_macros.svh"

module bearing_angle_image_pixel_top import bai_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bai_req_if.sink               req_if,
   bai_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [REG_W-1:0] row_length_ff, image_height_ff;
   logic [REG_W-1:0] len_eff, hgt_eff;
   logic [CNT_W-1:0] col_ff, row_ff, col_in, row_in;
   logic             cfg_wr, adv, accept, last_col, last_row, cnt_ok;
   logic [REG_W-1:0] pix_row_w, pix_col_w;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= ROW_LENGTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (cfg_wr) begin
         unique case (csr_paddr[REG_IDX_BIT])
            REG_IDX_ROW_LENGTH:   row_length_ff   <= csr_pwdata[REG_W-1:0];
            REG_IDX_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[REG_IDX_BIT])
         REG_IDX_ROW_LENGTH:   csr_prdata = CSR_DATA_W'(row_length_ff);
         REG_IDX_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(image_height_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      priority if (row_length_ff < MIN_ROW_LENGTH) begin
         len_eff = MIN_ROW_LENGTH;
      end else if (row_length_ff > REG_W'(MAX_ROW_LENGTH)) begin
         len_eff = REG_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = row_length_ff;
      end
      priority if (image_height_ff < MIN_ROWS) begin
         hgt_eff = MIN_ROWS;
      end else if (image_height_ff > REG_W'(MAX_ROWS)) begin
         hgt_eff = REG_W'(MAX_ROWS);
      end else begin
         hgt_eff = image_height_ff;
      end
   end

   // ---------------- counters and line store
   logic skid_v_ff;

   assign adv          = ~skid_v_ff;
   assign req_if.ready = adv;
   assign accept       = req_if.valid & adv;
   assign last_col     = {1'b0, col_ff} == len_eff - REG_W'(1);
   assign last_row     = {1'b0, row_ff} == hgt_eff - REG_W'(1);
   assign cnt_ok       = ({1'b0, col_ff} < len_eff) && ({1'b0, row_ff} < hgt_eff);
   assign pix_row_w    = hgt_eff - {1'b0, row_ff} - REG_W'(1);
   assign pix_col_w    = len_eff - {1'b0, col_ff} - REG_W'(1);

   always_comb begin
      col_in = col_ff + CNT_W'(1);
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   point_type pt_in, q_pt;

   assign pt_in = '{x: req_if.x, y: req_if.y, z: req_if.z};

   bai_line_store u_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (pt_in),
      .rd_en   (accept),
      .rd_addr (col_ff + ADDR_W'(1)),
      .rd_data (q_pt)
   );

   // ---------------- front stages
   logic     vld0_ff, vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   side_type side0_ff, side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side0_in, side5_in;
   point_type p0_ff;

   logic signed [COORD_W-1:0] pc0 [3];
   logic signed [COORD_W-1:0] qc0 [3];
   logic signed [COORD_W-1:0] p1_ff [3];
   logic signed [DIFF_W-1:0]  d1_ff [3];
   logic [COORD_W-1:0]        pm2_ff [3];
   logic [DIFF_W-1:0]         dm2_ff [3];
   logic                      neg2_ff [3];
   logic [2*COORD_W-1:0]      sqp3_ff [3];
   logic [2*DIFF_W-1:0]       sqd3_ff [3];
   logic [COORD_W+DIFF_W-1:0] x3_ff [3];
   logic                      neg3_ff [3];
   logic [MUL_W-1:0]          a4_ff, b4_ff, np4_ff, nn4_ff;
   logic [MUL_W-1:0]          a5_ff, b5_ff, nm5_ff;
   logic [MUL_W:0]            npn_diff;

   always_comb begin
      side0_in.zero      = (row_ff == '0) || ({1'b0, col_ff} + REG_W'(1) >= len_eff);
      side0_in.npos      = 1'b0;
      side0_in.pixel_row = pix_row_w[PIX_W-1:0];
      side0_in.pixel_col = pix_col_w[PIX_W-1:0];
      side0_in.frame_end = last_row & last_col;
   end

   assign pc0[0] = p0_ff.x;
   assign pc0[1] = p0_ff.y;
   assign pc0[2] = p0_ff.z;
   assign qc0[0] = q_pt.x;
   assign qc0[1] = q_pt.y;
   assign qc0[2] = q_pt.z;
   assign npn_diff = {1'b0, np4_ff} - {1'b0, nn4_ff};

   always_comb begin
      side5_in      = side4_ff;
      side5_in.zero = side4_ff.zero || (a4_ff == '0) || (b4_ff == '0);
      side5_in.npos = ~npn_diff[MUL_W] && (np4_ff != nn4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= accept;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff    <= pt_in;
         side0_ff <= side0_in;
         side1_ff <= side0_ff;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         for (int i = 0; i < 3; i++) begin
            p1_ff[i]   <= pc0[i];
            d1_ff[i]   <= DIFF_W'(pc0[i]) - DIFF_W'(qc0[i]);
            pm2_ff[i]  <= p1_ff[i][COORD_W-1] ? -COORD_W'(p1_ff[i]) : COORD_W'(p1_ff[i]);
            dm2_ff[i]  <= d1_ff[i][DIFF_W-1] ? -DIFF_W'(d1_ff[i]) : DIFF_W'(d1_ff[i]);
            neg2_ff[i] <= p1_ff[i][COORD_W-1] ^ d1_ff[i][DIFF_W-1];
            sqp3_ff[i] <= (2*COORD_W)'(pm2_ff[i]) * (2*COORD_W)'(pm2_ff[i]);
            sqd3_ff[i] <= (2*DIFF_W)'(dm2_ff[i]) * (2*DIFF_W)'(dm2_ff[i]);
            x3_ff[i]   <= (COORD_W+DIFF_W)'(pm2_ff[i]) * (COORD_W+DIFF_W)'(dm2_ff[i]);
            neg3_ff[i] <= neg2_ff[i];
         end
         a4_ff  <= MUL_W'(sqp3_ff[0]) + MUL_W'(sqp3_ff[1]) + MUL_W'(sqp3_ff[2]);
         b4_ff  <= MUL_W'(sqd3_ff[0]) + MUL_W'(sqd3_ff[1]) + MUL_W'(sqd3_ff[2]);
         np4_ff <= (neg3_ff[0] ? '0 : MUL_W'(x3_ff[0]))
                 + (neg3_ff[1] ? '0 : MUL_W'(x3_ff[1]))
                 + (neg3_ff[2] ? '0 : MUL_W'(x3_ff[2]));
         nn4_ff <= (neg3_ff[0] ? MUL_W'(x3_ff[0]) : '0)
                 + (neg3_ff[1] ? MUL_W'(x3_ff[1]) : '0)
                 + (neg3_ff[2] ? MUL_W'(x3_ff[2]) : '0);
         a5_ff  <= a4_ff;
         b5_ff  <= b4_ff;
         nm5_ff <= npn_diff[MUL_W] ? nn4_ff - np4_ff : npn_diff[MUL_W-1:0];
         side5_ff <= side5_in;
      end
   end

   // ---------------- squares: N*N and A*B
   logic [PROD_W-1:0] nsq, ab;
   logic              vldm_ff  [3];
   side_type          sidem_ff [3];

   bai_mult u_mul_n (.clock(clock), .en(adv), .a(nm5_ff), .b(nm5_ff), .p(nsq));
   bai_mult u_mul_ab (.clock(clock), .en(adv), .a(a5_ff), .b(b5_ff), .p(ab));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vldm_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vldm_ff[0] <= vld5_ff;
         vldm_ff[1] <= vldm_ff[0];
         vldm_ff[2] <= vldm_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidem_ff[0] <= side5_ff;
         sidem_ff[1] <= sidem_ff[0];
         sidem_ff[2] <= sidem_ff[1];
      end
   end

   // ---------------- quotient and table search
   logic             div_v, srch_v, div_rnz;
   side_type         div_side, srch_side;
   logic [QUO_W-1:0] div_quo;
   logic [GRAY_W-1:0] srch_gray;

   bai_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vldm_ff[2]),
      .in_side   (sidem_ff[2]),
      .num       (nsq[WIDE_W-1:0]),
      .den       (ab[WIDE_W-1:0]),
      .out_valid (div_v),
      .out_side  (div_side),
      .quo       (div_quo),
      .rnz       (div_rnz)
   );

   bai_search u_search (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (div_v),
      .in_side   (div_side),
      .quo       (div_quo),
      .rnz       (div_rnz),
      .out_valid (srch_v),
      .out_side  (srch_side),
      .gray      (srch_gray)
   );

   // ---------------- output register and skid stage
   rsp_type srch_data, rsp_data_ff, skid_data_ff;
   logic    rsp_v_ff;

   assign srch_data = '{gray: srch_gray, pixel_row: srch_side.pixel_row,
                        pixel_col: srch_side.pixel_col, frame_end: srch_side.frame_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (adv) begin
         if (~rsp_v_ff || rsp_if.ready) begin
            rsp_v_ff <= srch_v;
         end else if (srch_v) begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_if.ready) begin
         rsp_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (~rsp_v_ff || rsp_if.ready) begin
            rsp_data_ff <= srch_data;
         end else begin
            skid_data_ff <= srch_data;
         end
      end else if (rsp_if.ready) begin
         rsp_data_ff <= skid_data_ff;
      end
   end

   assign rsp_if.valid     = rsp_v_ff;
   assign rsp_if.gray      = rsp_data_ff.gray;
   assign rsp_if.pixel_row = rsp_data_ff.pixel_row;
   assign rsp_if.pixel_col = rsp_data_ff.pixel_col;
   assign rsp_if.frame_end = rsp_data_ff.frame_end;

   `BAI_ASSERT(a_skid_behind_out, skid_v_ff |-> rsp_v_ff, "skid stage full with output empty")
   `BAI_ASSERT(a_counters_in_range, 1'b1 |-> cnt_ok, "column or row counter out of range")
   `BAI_ASSERT(a_last_col_cleared, rsp_v_ff && rsp_data_ff.pixel_col == '0 |-> rsp_data_ff.gray == '0, "last column pixel not cleared")
   `BAI_ASSERT(a_frame_end_corner, rsp_v_ff && rsp_data_ff.frame_end |-> rsp_data_ff.pixel_row == '0 && rsp_data_ff.pixel_col == '0, "frame end away from corner")

endmodule

// ===== rtl/bai_line_store.sv =====
module bai_line_store import bai_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  point_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output point_type         rd_data
);

   point_type mem [LINE_DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bai_mult.sv =====
module bai_mult import bai_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [MUL_W-1:0]  a,
   input  logic [MUL_W-1:0]  b,
   output logic [PROD_W-1:0] p
);

   localparam int PP_W  = 2 * LIMB_W;
   localparam int ROW_W = PP_W + 2 * LIMB_W;

   logic [PP_W-1:0]   pp_ff  [MUL_LIMBS][MUL_LIMBS];
   logic [ROW_W-1:0]  row_ff [MUL_LIMBS];
   logic [PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < MUL_LIMBS; i++) begin
            for (int j = 0; j < MUL_LIMBS; j++) begin
               pp_ff[i][j] <= PP_W'(a[i*LIMB_W +: LIMB_W]) * PP_W'(b[j*LIMB_W +: LIMB_W]);
            end
         end
         for (int i = 0; i < MUL_LIMBS; i++) begin
            row_ff[i] <= ROW_W'(pp_ff[i][0])
                       + (ROW_W'(pp_ff[i][1]) << LIMB_W)
                       + (ROW_W'(pp_ff[i][2]) << (2 * LIMB_W));
         end
         p_ff <= PROD_W'(row_ff[0])
               + (PROD_W'(row_ff[1]) << LIMB_W)
               + (PROD_W'(row_ff[2]) << (2 * LIMB_W));
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/bai_div.sv =====
module bai_div import bai_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  side_type          in_side,
   input  logic [WIDE_W-1:0] num,
   input  logic [WIDE_W-1:0] den,
   output logic              out_valid,
   output side_type          out_side,
   output logic [QUO_W-1:0]  quo,
   output logic              rnz
);

   logic              vld_ff  [QUO_W];
   side_type          side_ff [QUO_W];
   logic [REM_W-1:0]  rem_ff  [QUO_W];
   logic [WIDE_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic              vld_src;
      side_type          side_src;
      logic [REM_W-1:0]  rem_src;
      logic [WIDE_W-1:0] den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [REM_W:0]    diff;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign side_src = in_side;
         assign rem_src  = {1'b0, num};
         assign den_src  = den;
         assign quo_src  = '0;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign side_src = side_ff[s-1];
         assign rem_src  = {rem_ff[s-1][REM_W-2:0], 1'b0};
         assign den_src  = den_ff[s-1];
         assign quo_src  = quo_ff[s-1];
      end

      assign diff = {1'b0, rem_src} - {2'b00, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_src;
            den_ff[s]  <= den_src;
            rem_ff[s]  <= diff[REM_W] ? rem_src : diff[REM_W-1:0];
            quo_ff[s]  <= {quo_src[QUO_W-2:0], ~diff[REM_W]};
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign rnz       = |rem_ff[QUO_W-1];

endmodule

// ===== rtl/bai_search.sv =====
module bai_search import bai_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  side_type          in_side,
   input  logic [QUO_W-1:0]  quo,
   input  logic              rnz,
   output logic              out_valid,
   output side_type          out_side,
   output logic [GRAY_W-1:0] gray
);

   localparam int STAGES = IDX_W + 1;

   logic             vld_ff  [STAGES];
   side_type         side_ff [STAGES];
   logic [QUO_W-1:0] v_ff    [STAGES];
   logic [IDX_W-1:0] j_ff    [STAGES];
   logic             none_ff [STAGES];
   logic [QUO_W-1:0] v_in;

   assign v_in = in_side.npos ? quo + QUO_W'(rnz) : quo + QUO_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         v_ff[0]    <= v_in;
         j_ff[0]    <= '0;
         none_ff[0] <= v_in > COS_SQ[0];
      end
   end

   // settle one index bit a stage, top bit first
   for (genvar b = 0; b < IDX_W; b++) begin : g_bit
      logic [IDX_W-1:0] cand;

      assign cand = j_ff[b] | IDX_W'(1 << (IDX_W - 1 - b));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[b+1] <= 1'b0;
         end else if (en) begin
            vld_ff[b+1] <= vld_ff[b];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[b+1] <= side_ff[b];
            v_ff[b+1]    <= v_ff[b];
            none_ff[b+1] <= none_ff[b];
            j_ff[b+1]    <= (v_ff[b] <= COS_SQ[cand]) ? cand : j_ff[b];
         end
      end
   end

   always_comb begin
      priority if (side_ff[STAGES-1].zero) begin
         gray = '0;
      end else if (side_ff[STAGES-1].npos) begin
         gray = GRAY_W'(j_ff[STAGES-1]);
      end else if (none_ff[STAGES-1]) begin
         gray = GRAY_TOP;
      end else begin
         gray = GRAY_BACK - GRAY_W'(j_ff[STAGES-1]);
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

// ===== tb/tb_bearing_angle_image_pixel_top.sv =====
module tb_bearing_angle_image_pixel_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bai_pkg::*;

   localparam int          STALL_LIMIT = 4000;
   localparam int          SETTLE      = 100;
   localparam logic [63:0] PI_Q61_VAL  = 64'h6487ED5110B4611A;
   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

   logic clock;
   logic reset;

   bai_req_if req_if ();
   bai_rsp_if rsp_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bearing_angle_image_pixel_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   longint          cos_q30 [256];
   point_type       line_store [MAX_ROW_LENGTH];
   int              scan_col;
   int              scan_row;
   logic [10:0]     len_reg;
   logic [10:0]     hgt_reg;
   rsp_type         expected_pixels [$];

   int  errors;
   int  idle_cycles;
   int  hold_cycles;
   bit  calm;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 40);
   endfunction

   function automatic int active_len();
      int v;
      v = len_reg;
      if (v < 2) v = 2;
      if (v > MAX_ROW_LENGTH) v = MAX_ROW_LENGTH;
      return v;
   endfunction

   function automatic int active_height();
      int v;
      v = hgt_reg;
      if (v < 1) v = 1;
      if (v > MAX_ROWS) v = MAX_ROWS;
      return v;
   endfunction

   function automatic void build_cos_table();
      logic [63:0] step_ang;
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      longint      sum;
      step_ang = PI_Q61_VAL / 64'd255;
      for (int k = 0; k < 128; k++) begin
         ang    = (step_ang * 64'(k)) >> 31;
         ang_sq = (ang * ang) >> 30;
         term   = 64'd1 << 30;
         sum    = longint'(1) << 30;
         for (int n = 1; n <= 10; n++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         cos_q30[k]       = sum;
         cos_q30[255 - k] = -sum;
      end
   endfunction

   function automatic logic [GRAY_W-1:0] bearing_gray(point_type p, point_type q);
      logic signed [31:0]  pc [3];
      logic signed [31:0]  qc [3];
      logic signed [255:0] pv;
      logic signed [255:0] dv;
      logic signed [255:0] a;
      logic signed [255:0] b;
      logic signed [255:0] n;
      logic signed [255:0] nm;
      logic signed [255:0] lhs;
      logic signed [255:0] ab;
      logic signed [255:0] rhs;
      logic signed [255:0] t;
      bit                  npos;
      bit                  ok;
      pc = '{p.x, p.y, p.z};
      qc = '{q.x, q.y, q.z};
      a = '0;
      b = '0;
      n = '0;
      for (int i = 0; i < 3; i++) begin
         pv = pc[i];
         dv = pv - 256'(signed'(qc[i]));
         a  = a + pv * pv;
         b  = b + dv * dv;
         n  = n + pv * dv;
      end
      if (a == 0 || b == 0) begin
         return '0;
      end
      npos = n > 0;
      nm   = (n < 0) ? -n : n;
      lhs  = (nm * nm) <<< 60;
      ab   = a * b;
      for (int k = 255; k >= 0; k--) begin
         t = cos_q30[k];
         if (t >= 0 && !npos) begin
            ok = 1'b1;
         end else if (t <= 0 && npos) begin
            ok = 1'b0;
         end else begin
            rhs = t * t * ab;
            ok  = (t > 0) ? (lhs <= rhs) : (lhs >= rhs);
         end
         if (ok) begin
            return GRAY_W'(k);
         end
      end
      return '0;
   endfunction

   task automatic predict_pixel(point_type p);
      int      len;
      int      hgt;
      int      col;
      int      row;
      rsp_type e;
      len = active_len();
      hgt = active_height();
      col = (scan_col >= len) ? len - 1 : scan_col;
      row = (scan_row >= hgt) ? hgt - 1 : scan_row;
      e.gray = (row != 0 && col + 1 < len) ? bearing_gray(p, line_store[col + 1]) : '0;
      line_store[col] = p;
      e.pixel_row = PIX_W'(hgt - row - 1);
      e.pixel_col = PIX_W'(len - col - 1);
      e.frame_end = (row == hgt - 1 && col == len - 1);
      expected_pixels.push_back(e);
      col++;
      if (col >= len) begin
         col = 0;
         row++;
         if (row >= hgt) row = 0;
      end
      scan_col = col;
      scan_row = row;
   endtask

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return C_MIN;
         1: return C_MAX;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic logic signed [31:0] small_coord();
      return 32'(int'($urandom_range(0, 2097152)) - 1048576);
   endfunction

   function automatic point_type make_point();
      point_type nb;
      point_type p;
      int        kind;
      if (scan_row != 0 && scan_col + 1 < active_len()) begin
         nb = line_store[scan_col + 1];
      end else begin
         nb = '{small_coord(), small_coord(), small_coord()};
      end
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         p = '{$urandom, $urandom, $urandom};
      end else if (kind < 55) begin
         p = '{small_coord(), small_coord(), small_coord()};
      end else if (kind < 70) begin
         p.x = nb.x + 32'(int'($urandom_range(0, 64)) - 32);
         p.y = nb.y + 32'(int'($urandom_range(0, 64)) - 32);
         p.z = nb.z + 32'(int'($urandom_range(0, 64)) - 32);
      end else if (kind < 78) begin
         p = nb;
      end else if (kind < 83) begin
         p = '0;
      end else if (kind < 90) begin
         p = '{pick_extreme(), pick_extreme(), pick_extreme()};
      end else begin
         p.x = 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)) <<< 4;
         p.y = 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)) <<< 4;
         p.z = 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)) <<< 4;
      end
      return p;
   endfunction

   task automatic send_point(point_type p);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x     <= p.x;
      req_if.y     <= p.y;
      req_if.z     <= p.z;
      do @(posedge clock); while (!req_if.ready);
      predict_pixel(p);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [10:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {21'($urandom_range(0, 2097151)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_IDX_ROW_LENGTH) begin
         len_reg = value;
      end else begin
         hgt_reg = value;
      end
      scan_col = 0;
      scan_row = 0;
   endtask

   task automatic test_reset_sizes();
      repeat (6) send_point(make_point());
   endtask

   task automatic test_corner_angles();
      write_csr(REG_IDX_ROW_LENGTH, 11'd3);
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd3);
      // first row
      send_point('{C_MIN, C_MIN, C_MIN});
      send_point('{C_MAX, C_MAX, C_MAX});
      send_point('{32'sh0002_0000, 32'sd0, 32'sd0});
      // equal to neighbour, origin, last column
      send_point('{C_MAX, C_MAX, C_MAX});
      send_point('{32'sd0, 32'sd0, 32'sd0});
      send_point('{C_MIN, C_MAX, 32'sd0});
      // beam straight at and straight away from the neighbour
      send_point('{32'sh0001_0000, 32'sd0, 32'sd0});
      send_point('{32'sh0004_0000, 32'sd0, 32'sd0});
      send_point('{32'sd5, -32'sd7, 32'sd9});
      // next frame
      send_point('{32'sh0001_0000, 32'sd0, 32'sd0});
      send_point('{32'sh0002_0000, 32'sd0, 32'sd0});
      send_point('{32'sd0, 32'sh0001_0000, 32'sd0});
      send_point('{32'sh0002_0000, 32'sd0, 32'sd0});
      send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sd0});
      send_point('{C_MAX, C_MIN, C_MAX});
      send_point('{C_MIN, C_MAX, C_MIN});
      send_point('{C_MAX, C_MIN, C_MAX});
   endtask

   task automatic test_size_clamps();
      write_csr(REG_IDX_ROW_LENGTH, 11'd0);
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd0);
      repeat (5) send_point(make_point());
      write_csr(REG_IDX_ROW_LENGTH, 11'd1);
      repeat (4) send_point(make_point());
      write_csr(REG_IDX_ROW_LENGTH, 11'd2047);
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd2047);
      repeat (6) send_point(make_point());
      write_csr(REG_IDX_ROW_LENGTH, 11'd1024);
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd1024);
      repeat (6) send_point(make_point());
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd1);
      write_csr(REG_IDX_ROW_LENGTH, 11'd2);
      repeat (6) send_point(make_point());
   endtask

   task automatic test_backpressure();
      write_csr(REG_IDX_ROW_LENGTH, 11'd7);
      write_csr(REG_IDX_IMAGE_HEIGHT, 11'd5);
      calm = 1'b1;
      hold_cycles = 300;
      repeat (150) send_point(make_point());
      calm = 1'b0;
      wait_drained();
      repeat (40) send_point(make_point());
   endtask

   task automatic test_random_frames();
      int remaining;
      int chunk;
      remaining = 1650;
      while (remaining > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            write_csr(REG_IDX_ROW_LENGTH, 11'($urandom_range(2, 64)));
         end else begin
            write_csr(REG_IDX_ROW_LENGTH, 11'($urandom_range(2, 12)));
         end
         write_csr(REG_IDX_IMAGE_HEIGHT, 11'($urandom_range(1, 6)));
         calm  = ($urandom_range(0, 3) == 0);
         chunk = $urandom_range(30, 120);
         for (int i = 0; i < chunk; i++) begin
            send_point(make_point());
            if (i == chunk / 2 && $urandom_range(0, 4) == 0) wait_drained();
         end
         remaining -= chunk;
      end
      calm = 1'b0;
   endtask

   // result side
   initial begin
      int stall_left;
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel gray=%0d row=%0d col=%0d end=%0b", $time,
                     rsp_if.gray, rsp_if.pixel_row, rsp_if.pixel_col, rsp_if.frame_end);
            errors++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_if.gray !== e.gray) begin
               $display("%0t: gray expected %0d actual %0d", $time, e.gray, rsp_if.gray);
               errors++;
            end
            if (rsp_if.pixel_row !== e.pixel_row) begin
               $display("%0t: pixel_row expected %0d actual %0d", $time, e.pixel_row,
                        rsp_if.pixel_row);
               errors++;
            end
            if (rsp_if.pixel_col !== e.pixel_col) begin
               $display("%0t: pixel_col expected %0d actual %0d", $time, e.pixel_col,
                        rsp_if.pixel_col);
               errors++;
            end
            if (rsp_if.frame_end !== e.frame_end) begin
               $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end,
                        rsp_if.frame_end);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_bearing_angle_image_pixel_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.x     = '0;
      req_if.y     = '0;
      req_if.z     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      errors       = 0;
      idle_cycles  = 0;
      hold_cycles  = 0;
      calm         = 1'b0;
      scan_col     = 0;
      scan_row     = 0;
      len_reg      = ROW_LENGTH_RESET;
      hgt_reg      = IMAGE_HEIGHT_RESET;
      build_cos_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_corner_angles();
      test_size_clamps();
      test_backpressure();
      test_random_frames();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("tb_bearing_angle_image_pixel_top: PASS");
      end else begin
         $display("tb_bearing_angle_image_pixel_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bai_pkg.sv
rtl/bai_if.sv
rtl/bai_line_store.sv
rtl/bai_mult.sv
rtl/bai_div.sv
rtl/bai_search.sv
rtl/bearing_angle_image_pixel_top.sv
tb/tb_bearing_angle_image_pixel_top.sv
